// ===== src/bmsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmsfc_pkg
// Shared types and constants of the battery-monitor reply frame checker.
// ----------------------------------------------------------------------------
package bmsfc_pkg;

  // Declared frame size is the length byte plus this overhead
  localparam logic [8:0] LEN_OVERHEAD = 9'd7;

  // Reset value of the expected byte count register
  localparam logic [5:0] EXP_BYTES_RST = 6'h22;

  // Fixed byte positions within a frame
  localparam int unsigned POS_SUM_FIRST = 2;
  localparam int unsigned POS_LEN       = 3;
  localparam int unsigned POS_FLD_FIRST = 4;
  localparam int unsigned POS_PROT_HI   = 20;
  localparam int unsigned POS_PROT_LO   = 21;
  localparam int unsigned POS_PERCENT   = 23;

  // Number of 16-bit captured fields, the last is the protection word
  localparam int unsigned N_FIELDS = 5;
  localparam int unsigned PROT_SLOT = 4;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_COUNT = 2'd1,
    STAT_SIZE  = 2'd2,
    STAT_CSUM  = 2'd3
  } frame_status_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } rx_word_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [15:0] pack_voltage;
    logic [15:0] pack_current;
    logic [15:0] remaining_capacity;
    logic [15:0] nominal_capacity;
    logic [15:0] protection_status;
    logic [7:0]  charge_percent;
  } res_word_t;

  typedef logic [5:0] cfg_word_t;

endpackage

// ===== src/bmsfc_chan_if.sv =====
// ----------------------------------------------------------------------------
// bmsfc_chan_if
// Valid/ready channel carrying one payload word per handshake.
// ----------------------------------------------------------------------------
interface bmsfc_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/bmsfc_res_buf.sv =====
// ----------------------------------------------------------------------------
// bmsfc_res_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module bmsfc_res_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bmsfc_pkg::res_word_t push_data_i,
  output logic                 space_o,
  bmsfc_chan_if.source         res_o
);

  logic                 main_v_q, main_v_d;
  logic                 skid_v_q, skid_v_d;
  bmsfc_pkg::res_word_t main_q, main_d;
  bmsfc_pkg::res_word_t skid_q, skid_d;
  logic                 pop;

  assign pop     = main_v_q && res_o.ready;
  // push only arrives while the skid slot is free
  assign space_o = !skid_v_q;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (pop || !main_v_q) begin
      if (skid_v_q) begin
        main_v_d = 1'b1;
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end else if (push_i) begin
        main_v_d = 1'b1;
        main_d   = push_data_i;
      end else begin
        main_v_d = 1'b0;
      end
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign res_o.valid   = main_v_q;
  assign res_o.payload = main_q;

endmodule

// ===== src/bms_response_frame_checker_top.sv =====
// ----------------------------------------------------------------------------
// bms_response_frame_checker_top
// Checks one battery-monitor reply frame per run of bytes and reports status
// plus the captured measurement fields on the last byte.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Word                         | Notes
//  --------+-----+------------------------------+-------------------------------
//  rx_i    | in  | rx_byte, frame_end           | one frame byte per word
//  res_o   | out | status + six captured fields | one word per frame
//  cfg_i   | in  | expected_frame_bytes (6 bit) | always ready, write when idle
//
//  One byte is taken per cycle; the frame state is updated at the edge that
//  accepts the byte. The result of a frame is registered at the edge that
//  accepts its last byte, in the output register or, if that is held, the skid.
//  A two-entry result buffer (output register + skid) lets bytes keep flowing
//  while a result waits; rx_i stalls only when both entries are held.
//  Reset (rst_ni low, asynchronous) clears frame state and the buffer and sets
//  the expected byte count to 34.
// ----------------------------------------------------------------------------
module bms_response_frame_checker_top #(
  parameter int unsigned MAX_FRAME_BYTES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bmsfc_chan_if.sink   rx_i,
  bmsfc_chan_if.source res_o,
  bmsfc_chan_if.sink   cfg_i
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAME_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_FRAME_BYTES - 1);

  // expected_frame_bytes register
  logic [5:0] exp_q;

  // Frame state
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             ovf_q, ovf_d;
  logic [8:0]       dsize_q, dsize_d;
  logic [15:0]      sum_q, sum_d;
  logic [15:0]      csum_q, csum_d;
  logic [15:0]      fld_q [bmsfc_pkg::N_FIELDS];
  logic [15:0]      fld_d [bmsfc_pkg::N_FIELDS];
  logic [7:0]       pct_q, pct_d;

  // State after taking the current byte, before end-of-frame clearing
  logic [IDX_W-1:0] idx_u;
  logic             ovf_u;
  logic [8:0]       dsize_u;
  logic [15:0]      sum_u;
  logic [15:0]      csum_u;
  logic [15:0]      fld_u [bmsfc_pkg::N_FIELDS];
  logic [7:0]       pct_u;

  logic                     rx_acc;
  logic                     buf_space;
  logic                     push;
  logic [7:0]               b;
  logic [9:0]               pos_w;
  bmsfc_pkg::frame_status_e status;
  bmsfc_pkg::res_word_t     res_word;

  assign b      = rx_i.payload.rx_byte;
  assign rx_acc = rx_i.valid && rx_i.ready;
  assign push   = rx_acc && rx_i.payload.frame_end;
  assign pos_w  = 10'(idx_q);

  assign rx_i.ready  = buf_space;
  assign cfg_i.ready = 1'b1;

  // --- byte intake ----------------------------------------------------------
  always_comb begin
    idx_u   = idx_q;
    ovf_u   = ovf_q;
    dsize_u = dsize_q;
    sum_u   = sum_q;
    csum_u  = csum_q;
    fld_u   = fld_q;
    pct_u   = pct_q;
    if (!ovf_q) begin
      // length byte: declared size is usable on the same byte
      if (idx_q == IDX_W'(bmsfc_pkg::POS_LEN)) begin
        dsize_u = 9'(b) + bmsfc_pkg::LEN_OVERHEAD;
      end
      if (idx_q == IDX_W'(bmsfc_pkg::POS_SUM_FIRST) ||
          (idx_q >= IDX_W'(bmsfc_pkg::POS_LEN) &&
           (pos_w + 10'd3) < 10'(dsize_u))) begin
        sum_u = sum_q + 16'(b);
      end
      if (dsize_u != 9'd0 && (pos_w + 10'd3) == 10'(dsize_u)) begin
        csum_u[15:8] = b;
      end
      if (dsize_u != 9'd0 && (pos_w + 10'd2) == 10'(dsize_u)) begin
        csum_u[7:0] = b;
      end
      for (int k = 0; k < bmsfc_pkg::PROT_SLOT; k++) begin
        if (idx_q == IDX_W'(bmsfc_pkg::POS_FLD_FIRST + 2 * k)) begin
          fld_u[k][15:8] = b;
        end
        if (idx_q == IDX_W'(bmsfc_pkg::POS_FLD_FIRST + 2 * k + 1)) begin
          fld_u[k][7:0] = b;
        end
      end
      if (idx_q == IDX_W'(bmsfc_pkg::POS_PROT_HI)) begin
        fld_u[bmsfc_pkg::PROT_SLOT][15:8] = b;
      end
      if (idx_q == IDX_W'(bmsfc_pkg::POS_PROT_LO)) begin
        fld_u[bmsfc_pkg::PROT_SLOT][7:0] = b;
      end
      if (idx_q == IDX_W'(bmsfc_pkg::POS_PERCENT)) begin
        pct_u = b;
      end
      // index sticks at the last slot once the frame runs too long
      if (idx_q == IDX_LAST) begin
        ovf_u = 1'b1;
      end else begin
        idx_u = idx_q + IDX_W'(1);
      end
    end
  end

  // --- checks, in priority order -------------------------------------------
  always_comb begin
    if (ovf_u || 9'(idx_u) != 9'(exp_q)) begin
      status = bmsfc_pkg::STAT_COUNT;
    end else if (dsize_u > 9'(exp_q)) begin
      status = bmsfc_pkg::STAT_SIZE;
    end else if (dsize_u == 9'd0 || (16'd0 - sum_u) != csum_u) begin
      status = bmsfc_pkg::STAT_CSUM;
    end else begin
      status = bmsfc_pkg::STAT_OK;
    end
  end

  always_comb begin
    res_word.frame_status       = status;
    res_word.pack_voltage       = fld_u[0];
    res_word.pack_current       = fld_u[1];
    res_word.remaining_capacity = fld_u[2];
    res_word.nominal_capacity   = fld_u[3];
    res_word.protection_status  = fld_u[bmsfc_pkg::PROT_SLOT];
    res_word.charge_percent     = pct_u;
  end

  // --- next state: hold, take byte, or clear after the last byte ------------
  always_comb begin
    idx_d   = idx_q;
    ovf_d   = ovf_q;
    dsize_d = dsize_q;
    sum_d   = sum_q;
    csum_d  = csum_q;
    fld_d   = fld_q;
    pct_d   = pct_q;
    if (push) begin
      idx_d   = '0;
      ovf_d   = 1'b0;
      dsize_d = '0;
      sum_d   = '0;
      csum_d  = '0;
      for (int k = 0; k < bmsfc_pkg::N_FIELDS; k++) begin
        fld_d[k] = '0;
      end
      pct_d   = '0;
    end else if (rx_acc) begin
      idx_d   = idx_u;
      ovf_d   = ovf_u;
      dsize_d = dsize_u;
      sum_d   = sum_u;
      csum_d  = csum_u;
      fld_d   = fld_u;
      pct_d   = pct_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q   <= bmsfc_pkg::EXP_BYTES_RST;
      idx_q   <= '0;
      ovf_q   <= 1'b0;
      dsize_q <= '0;
      sum_q   <= '0;
      csum_q  <= '0;
      for (int k = 0; k < bmsfc_pkg::N_FIELDS; k++) begin
        fld_q[k] <= '0;
      end
      pct_q   <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        exp_q <= cfg_i.payload;
      end
      idx_q   <= idx_d;
      ovf_q   <= ovf_d;
      dsize_q <= dsize_d;
      sum_q   <= sum_d;
      csum_q  <= csum_d;
      fld_q   <= fld_d;
      pct_q   <= pct_d;
    end
  end

  // --- result buffer --------------------------------------------------------
  bmsfc_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res_word),
    .space_o     (buf_space),
    .res_o       (res_o)
  );

endmodule
